@@ src/directory_listing_parser_top_macros.svh @@
// Assertion macros shared by the directory listing parser modules.
`ifndef DIRECTORY_LISTING_PARSER_TOP_MACROS_SVH
`define DIRECTORY_LISTING_PARSER_TOP_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define DLP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define DLP_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`endif

@@ src/dlp_pkg.sv @@
// Types and constants of the directory listing parser.
package dlp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ENTRY,
    PH_NAME,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    ST_NAME_BYTE      = 3'd0,
    ST_ENTRY_DONE     = 3'd1,
    ST_LISTING_DONE   = 3'd2,
    ST_HEADER_OVERRUN = 3'd3,
    ST_GROUP_TOO_BIG  = 3'd4,
    ST_ENTRY_OVERRUN  = 3'd5,
    ST_BAD_NAME_LEN   = 3'd6
  } status_e;

  localparam logic [31:0] SizeBias       = 32'd3;
  localparam logic [31:0] MinListingSize = 32'd4;
  localparam logic [31:0] HeaderBytes    = 32'd12;
  localparam logic [31:0] EntryBytes     = 32'd8;
  localparam logic [15:0] MaxNameLen     = 16'd256;
  localparam logic [3:0]  HeaderLastIdx  = 4'd11;
  localparam logic [3:0]  EntryLastIdx   = 4'd7;

  typedef struct packed {
    logic        mode;
    logic [31:0] listing_size;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  name_byte;
    logic        name_valid;
    logic [8:0]  name_length;
    logic [31:0] inode_block_start;
    logic [15:0] inode_block_offset;
    logic        listing_done;
  } out_t;

  // One result from the parser core toward the output stage.
  typedef struct packed {
    logic valid;
    out_t item;
  } res_t;

endpackage

@@ src/dlp_core.sv @@
// Parser state and per-item next-state and result logic.
`include "directory_listing_parser_top_macros.svh"

module dlp_core #(
  parameter int unsigned MAX_GROUP_ENTRIES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  dlp_pkg::in_t in_item_i,
  output dlp_pkg::res_t res_o
);

  dlp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [31:0] br_q, br_d;
  logic [8:0]  gel_q, gel_d;
  logic [31:0] gsb_q, gsb_d;
  logic [15:0] ofs_q, ofs_d;
  logic [8:0]  nbl_q, nbl_d;
  logic [31:0] asm_q, asm_d;

  logic [15:0] name_span;
  logic [8:0]  gel_dec;
  logic        finish;
  logic [7:0]  fin_byte;
  logic        fin_valid;

  assign gel_dec = gel_q - 9'd1;

  always_comb begin
    phase_d   = phase_q;
    fbc_d     = fbc_q;
    br_d      = br_q;
    gel_d     = gel_q;
    gsb_d     = gsb_q;
    ofs_d     = ofs_q;
    nbl_d     = nbl_q;
    asm_d     = asm_q;
    name_span = '0;
    finish    = 1'b0;
    fin_byte  = '0;
    fin_valid = 1'b0;
    res_o     = '0;

    if (accept_i) begin
      if (!in_item_i.mode) begin
        // A start item always begins a fresh listing.
        fbc_d = '0;
        gel_d = '0;
        gsb_d = '0;
        ofs_d = '0;
        nbl_d = '0;
        asm_d = '0;
        if (in_item_i.listing_size < dlp_pkg::MinListingSize) begin
          br_d                    = '0;
          phase_d                 = dlp_pkg::PH_DONE;
          res_o.valid             = 1'b1;
          res_o.item.status       = dlp_pkg::ST_LISTING_DONE;
          res_o.item.listing_done = 1'b1;
        end else begin
          br_d    = in_item_i.listing_size - dlp_pkg::SizeBias;
          phase_d = dlp_pkg::PH_HEADER;
        end
      end else begin
        case (phase_q)
          dlp_pkg::PH_HEADER: begin
            if (fbc_q == '0 && br_q < dlp_pkg::HeaderBytes) begin
              phase_d           = dlp_pkg::PH_ERROR;
              res_o.valid       = 1'b1;
              res_o.item.status = dlp_pkg::ST_HEADER_OVERRUN;
            end else begin
              if (fbc_q == '0) begin
                asm_d = '0;
              end
              br_d = br_q - 32'd1;
              if (fbc_q < 4'd4) begin
                asm_d[8*fbc_q[1:0] +: 8] = in_item_i.data_byte;
              end else if (fbc_q < 4'd8) begin
                if (fbc_q == 4'd4) begin
                  gsb_d = '0;
                end
                gsb_d[8*fbc_q[1:0] +: 8] = in_item_i.data_byte;
              end
              if (fbc_q == dlp_pkg::HeaderLastIdx) begin
                fbc_d = '0;
                if (asm_q >= 32'(MAX_GROUP_ENTRIES)) begin
                  phase_d           = dlp_pkg::PH_ERROR;
                  res_o.valid       = 1'b1;
                  res_o.item.status = dlp_pkg::ST_GROUP_TOO_BIG;
                end else begin
                  gel_d   = asm_q[8:0] + 9'd1;
                  phase_d = dlp_pkg::PH_ENTRY;
                end
              end else begin
                fbc_d = fbc_q + 4'd1;
              end
            end
          end

          dlp_pkg::PH_ENTRY: begin
            if (fbc_q == '0 && br_q < dlp_pkg::EntryBytes) begin
              phase_d           = dlp_pkg::PH_ERROR;
              res_o.valid       = 1'b1;
              res_o.item.status = dlp_pkg::ST_ENTRY_OVERRUN;
            end else begin
              if (fbc_q == '0) begin
                ofs_d = '0;
                asm_d = '0;
              end
              br_d = br_q - 32'd1;
              if (fbc_q < 4'd2) begin
                ofs_d[8*fbc_q[0] +: 8] = in_item_i.data_byte;
              end else if (fbc_q >= 4'd6) begin
                asm_d[8*fbc_q[0] +: 8] = in_item_i.data_byte;
              end
              if (fbc_q == dlp_pkg::EntryLastIdx) begin
                fbc_d     = '0;
                // Stored name size is one less than the length, mod 2^16.
                name_span = asm_d[15:0] + 16'd1;
                if (name_span > dlp_pkg::MaxNameLen || br_d < {16'd0, name_span}) begin
                  phase_d           = dlp_pkg::PH_ERROR;
                  res_o.valid       = 1'b1;
                  res_o.item.status = dlp_pkg::ST_BAD_NAME_LEN;
                end else begin
                  asm_d = {16'd0, name_span};
                  if (name_span == '0) begin
                    finish = 1'b1;
                  end else begin
                    nbl_d   = name_span[8:0];
                    phase_d = dlp_pkg::PH_NAME;
                  end
                end
              end else begin
                fbc_d = fbc_q + 4'd1;
              end
            end
          end

          dlp_pkg::PH_NAME: begin
            br_d  = br_q - 32'd1;
            nbl_d = nbl_q - 9'd1;
            if (nbl_d == '0) begin
              finish    = 1'b1;
              fin_byte  = in_item_i.data_byte;
              fin_valid = 1'b1;
            end else begin
              res_o.valid           = 1'b1;
              res_o.item.status     = dlp_pkg::ST_NAME_BYTE;
              res_o.item.name_byte  = in_item_i.data_byte;
              res_o.item.name_valid = 1'b1;
            end
          end

          default: begin
            // Idle, done or error: listing bytes are dropped.
          end
        endcase

        if (finish) begin
          gel_d = gel_dec;
          fbc_d = '0;
          if (gel_dec == '0) begin
            if (br_d == '0) begin
              phase_d                 = dlp_pkg::PH_DONE;
              res_o.item.listing_done = 1'b1;
            end else begin
              phase_d = dlp_pkg::PH_HEADER;
            end
          end else begin
            phase_d = dlp_pkg::PH_ENTRY;
          end
          res_o.valid                   = 1'b1;
          res_o.item.status             = dlp_pkg::ST_ENTRY_DONE;
          res_o.item.name_byte          = fin_byte;
          res_o.item.name_valid         = fin_valid;
          res_o.item.name_length        = asm_d[8:0];
          res_o.item.inode_block_start  = gsb_q;
          res_o.item.inode_block_offset = ofs_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dlp_pkg::PH_IDLE;
      fbc_q   <= '0;
      br_q    <= '0;
      gel_q   <= '0;
      gsb_q   <= '0;
      ofs_q   <= '0;
      nbl_q   <= '0;
      asm_q   <= '0;
    end else begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      br_q    <= br_d;
      gel_q   <= gel_d;
      gsb_q   <= gsb_d;
      ofs_q   <= ofs_d;
      nbl_q   <= nbl_d;
      asm_q   <= asm_d;
    end
  end

  `DLP_ASSERT(a_name_left_nonzero, clk_i, rst_ni,
    phase_q != dlp_pkg::PH_NAME || nbl_q != '0, "name phase with no name bytes left")
  `DLP_ASSERT(a_group_entries_live, clk_i, rst_ni,
    (phase_q != dlp_pkg::PH_ENTRY && phase_q != dlp_pkg::PH_NAME) ||
    (gel_q != '0 && 32'(gel_q) <= 32'(MAX_GROUP_ENTRIES)),
    "entry parsing outside a live group")
  `DLP_ASSERT(a_field_index_range, clk_i, rst_ni,
    (phase_q != dlp_pkg::PH_HEADER || fbc_q <= dlp_pkg::HeaderLastIdx) &&
    (phase_q != dlp_pkg::PH_ENTRY || fbc_q <= dlp_pkg::EntryLastIdx),
    "field byte index past end of field")

endmodule

@@ src/dlp_out_reg.sv @@
// Result register between the parser core and the output channel.
`include "directory_listing_parser_top_macros.svh"

module dlp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dlp_pkg::out_t item_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output dlp_pkg::out_t out_item_o
);

  logic          valid_q, valid_d;
  dlp_pkg::out_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  `DLP_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    push_i && valid_q && !out_ready_i, "result overwritten while stalled")

endmodule

@@ src/directory_listing_parser_top.sv @@
// Top level of the directory listing parser.
//
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one item per
// handshake. A start item (mode 0) opens a listing with its raw size; a data
// item (mode 1) carries one byte of the decompressed listing. The output
// channel (out_valid_o, out_ready_i, out_data_o) gives at most one result
// item for each input item: a name byte, a finished entry, the end of the
// listing or an error code.
// A result appears on the output in the cycle after the item that causes it
// is accepted. Throughput is one item per cycle while the receiver does not
// stall; all parsing is counter and compare logic between the state
// registers and the single result register.
// The result register is the only buffer. The input is ready whenever that
// register is empty or is being emptied in the same cycle, so a stalled
// receiver holds back the input only while a result is waiting.
// Reset puts the parser in its idle phase with all counters cleared and the
// result register empty; data items are ignored until a start item arrives.
module directory_listing_parser_top #(
  parameter int unsigned MAX_GROUP_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dlp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dlp_pkg::out_t out_data_o
);

  logic          accept;
  dlp_pkg::res_t res;

  // Accept a new item whenever the result register can take its result.
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  dlp_core #(
    .MAX_GROUP_ENTRIES(MAX_GROUP_ENTRIES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_item_i(in_data_i),
    .res_o    (res)
  );

  // The core only raises a result for an accepted item.
  dlp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res.valid),
    .item_i     (res.item),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_data_o)
  );

endmodule

@@ sim/dlp_listing_check_pkg.sv @@
// Expected-result prediction and result checking for the directory listing parser bench.
package dlp_listing_check_pkg;
  import dlp_pkg::*;

  localparam int unsigned GroupLimit = 256;

  // Values of the mode field of an input item.
  localparam logic ModeStart = 1'b0;
  localparam logic ModeByte  = 1'b1;

  class listing_scoreboard;
    phase_e      phase;
    logic [3:0]  field_idx;
    logic [31:0] bytes_left;
    logic [8:0]  entries_left;
    logic [31:0] group_block;
    logic [15:0] inode_ofs;
    logic [8:0]  name_left;
    logic [31:0] assembly;

    out_t        awaited[$];
    int unsigned checked;
    int unsigned mismatches;
    int unsigned status_hits[7];

    function new();
      clear_state();
      checked    = 0;
      mismatches = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void clear_state();
      phase        = PH_IDLE;
      field_idx    = '0;
      bytes_left   = '0;
      entries_left = '0;
      group_block  = '0;
      inode_ofs    = '0;
      name_left    = '0;
      assembly     = '0;
    endfunction

    function bit flag_error(status_e st, output out_t res);
      phase      = PH_ERROR;
      res        = '0;
      res.status = st;
      return 1'b1;
    endfunction

    // An entry is complete: step the group and listing bookkeeping.
    function bit close_entry(logic [7:0] nb, bit nv, output out_t res);
      res          = '0;
      entries_left = entries_left - 9'd1;
      field_idx    = '0;
      if (entries_left == 9'd0) begin
        if (bytes_left == 32'd0) begin
          phase            = PH_DONE;
          res.listing_done = 1'b1;
        end else begin
          phase = PH_HEADER;
        end
      end else begin
        phase = PH_ENTRY;
      end
      res.status             = ST_ENTRY_DONE;
      res.name_byte          = nb;
      res.name_valid         = nv;
      res.name_length        = assembly[8:0];
      res.inode_block_start  = group_block;
      res.inode_block_offset = inode_ofs;
      return 1'b1;
    endfunction

    // Advances the parser state by one item; returns 1 when it yields a result.
    function bit parse_item(in_t it, output out_t res);
      logic [3:0]  k;
      logic [31:0] nlen;
      res = '0;
      if (it.mode == ModeStart) begin
        clear_state();
        if (it.listing_size < MinListingSize) begin
          phase            = PH_DONE;
          res.status       = ST_LISTING_DONE;
          res.listing_done = 1'b1;
          return 1'b1;
        end
        bytes_left = it.listing_size - SizeBias;
        phase      = PH_HEADER;
        return 1'b0;
      end
      k = field_idx;
      case (phase)
        PH_HEADER: begin
          if (k == 4'd0) begin
            if (bytes_left < HeaderBytes) return flag_error(ST_HEADER_OVERRUN, res);
            assembly = '0;
          end
          bytes_left = bytes_left - 32'd1;
          if (k < 4'd4) begin
            assembly[8*k +: 8] = it.data_byte;
          end else if (k < 4'd8) begin
            if (k == 4'd4) group_block = '0;
            group_block[8*(k-4) +: 8] = it.data_byte;
          end
          if (k == HeaderLastIdx) begin
            field_idx = '0;
            if (assembly >= GroupLimit) return flag_error(ST_GROUP_TOO_BIG, res);
            entries_left = 9'(assembly + 32'd1);
            phase        = PH_ENTRY;
          end else begin
            field_idx = k + 4'd1;
          end
          return 1'b0;
        end
        PH_ENTRY: begin
          if (k == 4'd0) begin
            if (bytes_left < EntryBytes) return flag_error(ST_ENTRY_OVERRUN, res);
            inode_ofs = '0;
            assembly  = '0;
          end
          bytes_left = bytes_left - 32'd1;
          if (k < 4'd2) inode_ofs[8*k +: 8] = it.data_byte;
          else if (k >= 4'd6) assembly[8*(k-6) +: 8] = it.data_byte;
          if (k == EntryLastIdx) begin
            nlen      = (assembly + 32'd1) & 32'h0000_FFFF;
            field_idx = '0;
            if (nlen > MaxNameLen || bytes_left < nlen) return flag_error(ST_BAD_NAME_LEN, res);
            assembly = nlen;
            // A name size of all ones wraps to an empty name.
            if (nlen == 32'd0) return close_entry(8'h00, 1'b0, res);
            name_left = nlen[8:0];
            phase     = PH_NAME;
          end else begin
            field_idx = k + 4'd1;
          end
          return 1'b0;
        end
        PH_NAME: begin
          bytes_left = bytes_left - 32'd1;
          name_left  = name_left - 9'd1;
          if (name_left == 9'd0) return close_entry(it.data_byte, 1'b1, res);
          res.status     = ST_NAME_BYTE;
          res.name_byte  = it.data_byte;
          res.name_valid = 1'b1;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Records an accepted item; returns 1 unless the parser drops it.
    function bit note_input(in_t it);
      out_t res;
      bit   live;
      live = (it.mode == ModeStart) || (phase inside {PH_HEADER, PH_ENTRY, PH_NAME});
      if (parse_item(it, res)) awaited.push_back(res);
      return live;
    endfunction

    function string describe(out_t r);
      return $sformatf("status %0d byte %02h/%0b len %0d block %08h offset %04h done %0b",
                       r.status, r.name_byte, r.name_valid, r.name_length,
                       r.inode_block_start, r.inode_block_offset, r.listing_done);
    endfunction

    function void report(string why, out_t want, out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %s, got %s", why, describe(want), describe(got));
    endfunction

    function void check_result(out_t got);
      out_t  want;
      string bad;
      if (awaited.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = awaited.pop_front();
      bad  = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.name_byte !== want.name_byte) bad = {bad, " name_byte"};
      if (got.name_valid !== want.name_valid) bad = {bad, " name_valid"};
      if (got.name_length !== want.name_length) bad = {bad, " name_length"};
      if (got.inode_block_start !== want.inode_block_start) bad = {bad, " block_start"};
      if (got.inode_block_offset !== want.inode_block_offset) bad = {bad, " inode_offset"};
      if (got.listing_done !== want.listing_done) bad = {bad, " listing_done"};
      checked++;
      status_hits[want.status]++;
      if (bad != "") report({"field mismatch:", bad}, want, got);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

endpackage

@@ sim/directory_listing_parser_top_tb.sv @@
// Self-checking testbench for the directory listing parser top level.
module directory_listing_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dlp_pkg::*;
  import dlp_listing_check_pkg::*;

  // Shapes of listing that the stimulus generator can produce. Most are well
  // formed listings whose size field is then cut at a chosen spot, so that
  // each error is reached after real parsing work rather than at once.
  typedef enum int {
    LS_CLEAN,
    LS_TRAILING,
    LS_HDR_SHORT,
    LS_ENTRY_SHORT,
    LS_NAME_SHORT,
    LS_BIG_GROUP,
    LS_BAD_LEN,
    LS_EMPTY_NAME,
    LS_LONG_NAME,
    LS_FULL_GROUP,
    LS_CUT,
    LS_NOISE,
    LS_ODD_SIZE
  } listing_kind_e;

  localparam int unsigned RandomItems = 200;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  listing_scoreboard sb;

  // While calm is set neither side of the block inserts bubbles.
  bit          calm;
  int unsigned work_items;
  int unsigned items_sent;
  int unsigned listings_run;

  // Byte image of the listing under construction, plus the offsets where each
  // header, each entry and each name begins. The offsets let a listing size be
  // chosen so that the listing ends inside one specific field.
  logic [7:0]  listing_bytes[$];
  int          hdr_marks[$];
  int          entry_marks[$];
  int          name_marks[$];
  int          name_lens[$];

  directory_listing_parser_top #(
    .MAX_GROUP_ENTRIES(GroupLimit)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Roughly one cycle in five is a bubble, except inside the calm stretch.
  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 20);
  endfunction

  // Offers one item from a falling edge on and holds it until the block takes
  // it. Valid is written once per falling edge, so it never glitches low
  // between two back-to-back items.
  task automatic drive_item(input in_t it);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (sb.note_input(it)) work_items++;
    items_sent++;
  endtask

  // The unused field of each item carries random bits; the block must not care.
  task automatic send_start(input logic [31:0] size);
    in_t it;
    it              = '0;
    it.mode         = ModeStart;
    it.listing_size = size;
    it.data_byte    = 8'($urandom());
    drive_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_t it;
    it              = '0;
    it.mode         = ModeByte;
    it.listing_size = $urandom();
    it.data_byte    = b;
    drive_item(it);
  endtask

  task automatic push_le(input logic [31:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) listing_bytes.push_back(v[8*i +: 8]);
  endtask

  // Builds the byte image of one listing and picks the size field and the
  // number of bytes to send according to the requested shape.
  task automatic compose_listing(input listing_kind_e kind, output logic [31:0] size,
                                 output int send_len);
    int          groups;
    int          count;
    int          nlen;
    int          pick;
    int          g;
    int          e;
    int          len;
    logic [31:0] count_field;
    logic [15:0] name_field;
    bit          stop;
    listing_bytes.delete();
    hdr_marks.delete();
    entry_marks.delete();
    name_marks.delete();
    name_lens.delete();
    stop   = 1'b0;
    groups = (kind == LS_FULL_GROUP || $urandom_range(0, 3) != 0) ? 1 : $urandom_range(2, 3);
    for (g = 0; g < groups && !stop; g++) begin
      hdr_marks.push_back(listing_bytes.size());
      // Groups are kept small; the largest allowed count appears once.
      if (kind == LS_FULL_GROUP) count = GroupLimit - 1;
      else if ($urandom_range(0, 3) == 0) count = $urandom_range(2, 4);
      else count = $urandom_range(0, 1);
      count_field = count;
      if (kind == LS_BIG_GROUP && g == groups - 1) begin
        // Either exactly one past the limit or a count with random high bits.
        count_field = $urandom_range(0, 1) ? GroupLimit : ($urandom() | GroupLimit);
        stop        = 1'b1;
      end
      push_le(count_field, 4);
      push_le($urandom(), 4);
      push_le($urandom(), 4);
      for (e = 0; e <= count && !stop; e++) begin
        entry_marks.push_back(listing_bytes.size());
        name_field = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 7));
        if (kind == LS_FULL_GROUP) begin
          name_field = 16'hFFFF;
        end else if (g == 0 && e == 0 && kind == LS_EMPTY_NAME) begin
          name_field = 16'hFFFF;
        end else if (g == 0 && e == 0 && kind == LS_LONG_NAME) begin
          name_field = 16'd255;
        end else if (g == groups - 1 && e == count && kind == LS_BAD_LEN) begin
          name_field = 16'($urandom_range(256, 16'hFFFE));
          stop       = 1'b1;
        end
        // Inode offset and inode number, then type, then the name size.
        push_le($urandom(), 4);
        push_le($urandom(), 2);
        push_le(name_field, 2);
        nlen = (int'(name_field) + 1) % 65536;
        if (stop) begin
          // A few stray bytes follow the bad length; all must be dropped.
          nlen = $urandom_range(0, 3);
        end else if (nlen > 0) begin
          name_marks.push_back(listing_bytes.size());
          name_lens.push_back(nlen);
        end
        repeat (nlen) listing_bytes.push_back(8'($urandom()));
      end
    end
    len      = listing_bytes.size();
    size     = 32'(len) + SizeBias;
    send_len = len;
    case (kind)
      LS_TRAILING: begin
        repeat ($urandom_range(1, 4)) listing_bytes.push_back(8'($urandom()));
        send_len = listing_bytes.size();
      end
      LS_HDR_SHORT: begin
        // One to eleven bytes left where a group header should start.
        pick = $urandom_range(0, hdr_marks.size() - 1);
        size = 32'(hdr_marks[pick]) + SizeBias + 32'($urandom_range(1, 11));
      end
      LS_ENTRY_SHORT: begin
        // Fewer than eight bytes left where an entry should start.
        pick = $urandom_range(0, entry_marks.size() - 1);
        size = 32'(entry_marks[pick]) + SizeBias + 32'($urandom_range(0, 7));
      end
      LS_NAME_SHORT: begin
        // The name announced by an entry runs past the end of the listing.
        if (name_marks.size() > 0) begin
          pick = $urandom_range(0, name_marks.size() - 1);
          size = 32'(name_marks[pick]) + SizeBias + 32'($urandom_range(0, name_lens[pick] - 1));
        end else begin
          size = 32'(entry_marks[0]) + SizeBias + 32'($urandom_range(0, 7));
        end
      end
      LS_FULL_GROUP: begin
        // The group count at the limit is loaded in full, then the listing
        // runs out a few entries in, which ends it with an entry overrun.
        pick     = $urandom_range(4, 12);
        size     = 32'(entry_marks[pick]) + SizeBias + 32'($urandom_range(0, 7));
        send_len = entry_marks[pick] + 8;
      end
      LS_CUT: begin
        // Stop partway; the next start item must begin a fresh listing.
        send_len = $urandom_range(0, len - 1);
      end
      LS_NOISE: begin
        listing_bytes.delete();
        repeat ($urandom_range(0, 30)) listing_bytes.push_back(8'($urandom()));
        size     = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 48));
        send_len = listing_bytes.size();
      end
      LS_ODD_SIZE: begin
        size = 32'(len + 3 + int'($urandom_range(0, 40)) - 20);
      end
      default: ;
    endcase
  endtask

  task automatic run_listing(input listing_kind_e kind);
    logic [31:0] size;
    int          send_len;
    int          i;
    compose_listing(kind, size, send_len);
    send_start(size);
    for (i = 0; i < send_len; i++) send_byte(listing_bytes[i]);
    listings_run++;
  endtask

  // Clean listings dominate so that the deeper states see most of the traffic.
  function automatic listing_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return LS_CLEAN;
    if (r < 48) return LS_TRAILING;
    if (r < 56) return LS_HDR_SHORT;
    if (r < 64) return LS_ENTRY_SHORT;
    if (r < 72) return LS_NAME_SHORT;
    if (r < 77) return LS_BIG_GROUP;
    if (r < 82) return LS_BAD_LEN;
    if (r < 88) return LS_CUT;
    if (r < 94) return LS_NOISE;
    if (r < 97) return LS_ODD_SIZE;
    return LS_EMPTY_NAME;
  endfunction

  // The receiver stalls at random, again except inside the calm stretch.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !take_break();
    end
  end

  // Every result taken by the receiver is checked against the oldest
  // expectation.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end
  end

  initial begin
    int kidx;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    work_items   = 0;
    items_sent   = 0;
    listings_run = 0;
    sb           = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A byte before any start item is dropped.
    send_byte(8'hFF);
    // Sizes below four are empty listings that end at once.
    send_start(32'd0);
    send_start(SizeBias);
    // A byte after a clean end is dropped.
    send_byte(8'h00);
    // A single listing byte is too short for a group header; the byte after
    // the error is dropped.
    send_start(MinListingSize);
    send_byte(8'hA5);
    send_byte(8'h5A);
    // The largest size, abandoned partway through the header by a new start.
    send_start(32'hFFFF_FFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_start(32'hFFFF_FFFF);
    // A group count at least one past the limit, with random upper bytes.
    send_byte(8'h00);
    send_byte(8'h01);
    repeat (10) send_byte(8'($urandom()));

    // One listing of every shape, including a group count at the limit and
    // the longest name.
    for (kidx = LS_CLEAN; kidx <= LS_ODD_SIZE; kidx++) run_listing(listing_kind_e'(kidx));

    // Random part, with a stretch in the middle where nobody stalls.
    work_items = 0;
    while (work_items < RandomItems) begin
      calm = (work_items >= 60 && work_items < 140);
      run_listing(pick_kind());
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for the last results, then a few cycles more for anything extra.
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d listings in %0d input items; %0d results checked.",
             listings_run, items_sent, sb.checked);
    $display("Seen: %0d name bytes, %0d entries, %0d empty listings, %0d errors.",
             sb.status_hits[ST_NAME_BYTE], sb.status_hits[ST_ENTRY_DONE],
             sb.status_hits[ST_LISTING_DONE],
             sb.status_hits[ST_HEADER_OVERRUN] + sb.status_hits[ST_GROUP_TOO_BIG] +
             sb.status_hits[ST_ENTRY_OVERRUN] + sb.status_hits[ST_BAD_NAME_LEN]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("directory_listing_parser_top regression: pass");
    end else begin
      $display("Mismatches: %0d, results still pending: %0d", sb.mismatches, sb.pending());
      $display("directory_listing_parser_top regression: fail");
    end
    $finish;
  end

  // A hung handshake ends the run here; a correct run needs a small fraction
  // of this time.
  initial begin
    #2000000;
    $display("directory_listing_parser_top regression: fail");
    $finish;
  end

endmodule
